### sv/cse_pkg.sv
// cse_pkg: shared constants and types for the contour segment extractor
// no dependencies
package cse_pkg;

    localparam int DEF_MAX_ROW_LENGTH = 1024;
    localparam int DEF_MAX_LEVELS     = 16;
    localparam int DEF_FRACTION_BITS  = 8;
    localparam int DEF_SAMPLE_BITS    = 16;

    localparam int COORD_BITS  = 18;
    localparam int ROW_IDX_BITS = 10;
    localparam int LEVEL_BITS  = 5;
    localparam int CFG_BITS    = 16;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_BASE    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_TOP     = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_REQUEST = 2'd3;

    // cell job handed from the front to the back
    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic [12:0]        col;
        logic [ROW_IDX_BITS-1:0] row;
        logic               form;
    } cell_job_t;

endpackage

### sv/cse_div.sv
// cse_div: restoring divider, one quotient bit per cycle
// depends on cse_pkg
module cse_div
    import cse_pkg::*;
#(
    parameter int W = 48
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic         done,
    output logic [W-1:0] quot
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  d_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next;
    logic [W:0]    trial;

    assign trial = {rem_reg, q_reg[W-1]} - {1'b0, d_reg};

    // one shift and subtract step per cycle, done stays up until the next start
    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            rem_next  = '0;
            q_next    = num;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            if (!trial[W]) begin
                rem_next = trial[W-1:0];
                q_next   = {q_reg[W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[W-2:0], q_reg[W-1]};
                q_next   = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start) d_reg <= den;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

### sv/cse_front.sv
// cse_front: input beat acceptance, line store and cell assembly
// depends on cse_pkg
module cse_front
    import cse_pkg::*;
#(
    parameter int MAX_ROW_LENGTH = DEF_MAX_ROW_LENGTH,
    parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_value,
    input  logic                          s_frame_start,
    input  logic [10:0]                   row_length,
    output logic                          job_valid,
    input  logic                          job_ready,
    output cell_job_t                     job
);

    localparam int AW = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;

    typedef enum logic [1:0] {F_IDLE, F_READ} fstate_t;

    logic signed [SAMPLE_BITS-1:0] store_mem [MAX_ROW_LENGTH];
    logic signed [SAMPLE_BITS-1:0] rd_reg, smp_reg, left_reg, ul_reg;
    logic [AW-1:0]           col_reg;
    logic [ROW_IDX_BITS-1:0] row_reg;
    fstate_t                 st_reg;
    cell_job_t               job_reg;
    logic                    jv_reg;
    logic [AW-1:0]           c_eff;
    logic [ROW_IDX_BITS-1:0] r_eff;
    logic [12:0]             len_used;
    logic signed [SAMPLE_BITS-1:0] above;
    logic                    job_load;

    assign c_eff = s_frame_start ? '0 : col_reg;
    assign r_eff = s_frame_start ? '0 : row_reg;
    assign len_used = (row_length < 11'd2) ? 13'd2 :
                      ({2'b0, row_length} > 13'(MAX_ROW_LENGTH)) ? 13'(MAX_ROW_LENGTH) :
                      {2'b0, row_length};
    assign above = (row_reg == '0) ? '0 : rd_reg;
    assign s_ready = (st_reg == F_IDLE);
    // the job slot takes a new cell once it is empty or being taken
    assign job_load = (st_reg == F_READ) && (!jv_reg || job_ready);

    // line store read and write
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            rd_reg <= store_mem[c_eff];
            store_mem[c_eff] <= s_sample_value;
        end
    end

    // cell sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= F_IDLE;
            jv_reg   <= 1'b0;
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
            ul_reg   <= '0;
        end else begin
            if (job_load) jv_reg <= 1'b1;
            else if (job_ready) jv_reg <= 1'b0;
            case (st_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        smp_reg <= s_sample_value;
                        col_reg <= c_eff;
                        row_reg <= r_eff;
                        st_reg  <= F_READ;
                    end
                end
                F_READ: begin
                    if (job_load) begin
                        job_reg.a    <= 32'(left_reg);
                        job_reg.b    <= 32'(ul_reg);
                        job_reg.c    <= 32'(above);
                        job_reg.d    <= 32'(smp_reg);
                        job_reg.col  <= 13'(col_reg);
                        job_reg.row  <= row_reg;
                        job_reg.form <= (col_reg != '0) && (row_reg != '0);
                        left_reg <= smp_reg;
                        ul_reg   <= above;
                        if (13'(col_reg) + 13'd1 >= len_used) begin
                            col_reg <= '0;
                            if (row_reg != '1) row_reg <= row_reg + 1'b1;
                        end else begin
                            col_reg <= col_reg + 1'b1;
                        end
                        st_reg <= F_IDLE;
                    end
                end
                default: st_reg <= F_IDLE;
            endcase
        end
    end

    assign job_valid = jv_reg;
    assign job       = job_reg;

endmodule

### sv/cse_back.sv
// cse_back: level sweep, edge tests, interpolation and segment output
// depends on cse_pkg, cse_div
module cse_back
    import cse_pkg::*;
#(
    parameter int MAX_LEVELS    = DEF_MAX_LEVELS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    job_valid,
    output logic                    job_ready,
    input  cell_job_t               job,
    input  logic signed [15:0]      level_base,
    input  logic signed [15:0]      level_top,
    input  logic [4:0]              level_request,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [COORD_BITS-1:0]   m_start_x,
    output logic [COORD_BITS-1:0]   m_start_y,
    output logic [COORD_BITS-1:0]   m_end_x,
    output logic [COORD_BITS-1:0]   m_end_y,
    output logic [LEVEL_BITS-1:0]   m_level_number,
    output logic                    m_last_segment
);

    localparam int DW = 48;
    localparam logic signed [47:0] ONE = 48'sd1 <<< FRACTION_BITS;

    typedef enum logic [3:0] {
        B_IDLE, B_STEP, B_STEPW, B_LEVEL, B_EDGE, B_DIVW, B_PUT, B_FLUSH
    } bstate_t;

    bstate_t st_reg;
    cell_job_t cj_reg;
    logic [5:0]  k_reg, nlev;
    logic [1:0]  e_reg;
    logic signed [47:0] step_reg, lv_reg;
    logic        pend_reg;
    logic [COORD_BITS-1:0] px_reg, py_reg;
    logic [COORD_BITS-1:0] hx_reg, hy_reg;   // held segment
    logic [COORD_BITS-1:0] hex_reg, hey_reg;
    logic [COORD_BITS-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic [LEVEL_BITS-1:0] lvn_reg, hl_reg;
    logic        ov_reg, ol_reg, held_reg;
    logic        dstart;
    logic [DW-1:0] dnum, dden, dq;
    logic        ddone;
    logic signed [31:0] d0, d1, hi, lo;
    logic signed [47:0] d0s, his, los, diff;
    logic        crossed;
    logic signed [47:0] cx, cy, nx, ny;
    logic [6:0]  count_reg;
    logic        emit_new, seg_load;

    cse_div #(.W(DW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dstart),
        .num(dnum), .den(dden), .done(ddone), .quot(dq)
    );

    assign nlev = (level_request <= 5'd1) ? 6'd1 :
                  (6'(level_request) > 6'(MAX_LEVELS)) ? 6'(MAX_LEVELS) : 6'(level_request);

    // edge corners
    always_comb begin
        case (e_reg)
            2'd0: begin d0 = cj_reg.a; d1 = cj_reg.b; end
            2'd1: begin d0 = cj_reg.b; d1 = cj_reg.c; end
            2'd2: begin d0 = cj_reg.c; d1 = cj_reg.d; end
            default: begin d0 = cj_reg.d; d1 = cj_reg.a; end
        endcase
        hi  = (d0 > d1) ? d0 : d1;
        lo  = (d0 < d1) ? d0 : d1;
        d0s = 48'(d0) <<< FRACTION_BITS;
        his = 48'(hi) <<< FRACTION_BITS;
        los = 48'(lo) <<< FRACTION_BITS;
        diff = lv_reg - d0s;
        crossed = (lv_reg <= his) && (lv_reg > los);
        case (e_reg)
            2'd0: begin cx = 48'(cj_reg.col) - 48'sd1; cy = 48'(cj_reg.row); end
            2'd1: begin cx = 48'(cj_reg.col) - 48'sd1; cy = 48'(cj_reg.row) - 48'sd1; end
            2'd2: begin cx = 48'(cj_reg.col); cy = 48'(cj_reg.row) - 48'sd1; end
            default: begin cx = 48'(cj_reg.col); cy = 48'(cj_reg.row); end
        endcase
    end

    // divider operands: step division or edge offset
    always_comb begin
        dstart = 1'b0;
        dnum = '0;
        dden = 48'd1;
        if (st_reg == B_STEP) begin
            dstart = 1'b1;
            dnum = 48'(((48'(level_top) - 48'(level_base)) <<< FRACTION_BITS) < 0 ?
                   -((48'(level_top) - 48'(level_base)) <<< FRACTION_BITS) :
                    ((48'(level_top) - 48'(level_base)) <<< FRACTION_BITS));
            dden = 48'(nlev) + 48'd1;
        end else if (st_reg == B_EDGE && crossed) begin
            dstart = 1'b1;
            dnum = 48'(diff < 0 ? -diff : diff) + (48'(hi - lo) >> 1);
            dden = 48'(hi - lo);
        end
    end

    assign job_ready = (st_reg == B_IDLE);

    always_comb begin
        nx = cx <<< FRACTION_BITS;
        ny = cy <<< FRACTION_BITS;
        case (e_reg)
            2'd0: ny = ny - 48'(dq);
            2'd1: nx = nx + 48'(dq);
            2'd2: ny = ny + 48'(dq);
            default: nx = nx - 48'(dq);
        endcase
    end

    // a completed pair replaces the held segment once the output has room
    assign emit_new = (st_reg == B_DIVW) && ddone && pend_reg && (count_reg < 7'd32) &&
                      (!held_reg || !ov_reg || m_ready);
    assign seg_load = held_reg &&
                      (emit_new || ((st_reg == B_FLUSH) && (!ov_reg || m_ready)));

    // level and edge sequencer with one held segment for last-marking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= B_IDLE;
            ov_reg   <= 1'b0;
            held_reg <= 1'b0;
            pend_reg <= 1'b0;
        end else begin
            if (seg_load) ov_reg <= 1'b1;
            else if (m_ready) ov_reg <= 1'b0;
            case (st_reg)
                B_IDLE: begin
                    if (job_valid) begin
                        cj_reg   <= job;
                        held_reg <= 1'b0;
                        count_reg <= '0;
                        st_reg   <= job.form ? B_STEP : B_IDLE;
                    end
                end
                B_STEP: st_reg <= B_STEPW;
                B_STEPW: begin
                    if (ddone) begin
                        if (level_request <= 5'd1) step_reg <= ONE;
                        else if (level_top < level_base) step_reg <= -$signed(dq);
                        else step_reg <= $signed(dq);
                        lv_reg <= 48'(level_base) <<< FRACTION_BITS;
                        k_reg  <= 6'd1;
                        st_reg <= B_LEVEL;
                    end
                end
                B_LEVEL: begin
                    lv_reg   <= lv_reg + step_reg;
                    e_reg    <= 2'd0;
                    pend_reg <= 1'b0;
                    st_reg   <= B_EDGE;
                end
                B_EDGE: begin
                    if (crossed) st_reg <= B_DIVW;
                    else if (e_reg == 2'd3) begin
                        if (k_reg == nlev) st_reg <= B_FLUSH;
                        else begin k_reg <= k_reg + 1'b1; st_reg <= B_LEVEL; end
                    end else e_reg <= e_reg + 1'b1;
                end
                B_DIVW: begin
                    if (ddone) begin
                        if (!pend_reg) begin
                            px_reg <= nx[COORD_BITS-1:0];
                            py_reg <= ny[COORD_BITS-1:0];
                            pend_reg <= 1'b1;
                            st_reg <= B_PUT;
                        end else if (count_reg < 7'd32) begin
                            // wait for room to release the held segment
                            if (emit_new) begin
                                if (held_reg) begin
                                    sx_reg <= hx_reg; sy_reg <= hy_reg;
                                    lvn_reg <= hl_reg; ol_reg <= 1'b0;
                                end
                                held_reg <= 1'b1;
                                hx_reg <= px_reg; hy_reg <= py_reg;
                                hl_reg <= k_reg[LEVEL_BITS-1:0];
                                px_reg <= nx[COORD_BITS-1:0];
                                py_reg <= ny[COORD_BITS-1:0];
                                pend_reg <= 1'b0;
                                count_reg <= count_reg + 1'b1;
                                st_reg <= B_PUT;
                            end
                        end else begin
                            pend_reg <= 1'b0;
                            st_reg <= B_PUT;
                        end
                    end
                end
                B_PUT: begin
                    if (e_reg == 2'd3) begin
                        if (k_reg == nlev) st_reg <= B_FLUSH;
                        else begin k_reg <= k_reg + 1'b1; st_reg <= B_LEVEL; end
                    end else begin
                        e_reg <= e_reg + 1'b1;
                        st_reg <= B_EDGE;
                    end
                end
                B_FLUSH: begin
                    if (!held_reg) st_reg <= B_IDLE;
                    else if (!ov_reg || m_ready) begin
                        sx_reg <= hx_reg; sy_reg <= hy_reg;
                        lvn_reg <= hl_reg; ol_reg <= 1'b1;
                        held_reg <= 1'b0;
                        st_reg <= B_IDLE;
                    end
                end
                default: st_reg <= B_IDLE;
            endcase
        end
    end

    // end point of the held segment travels beside it
    always_ff @(posedge aclk) begin
        if (emit_new) begin
            hex_reg <= nx[COORD_BITS-1:0];
            hey_reg <= ny[COORD_BITS-1:0];
        end
        if (seg_load) begin
            ex_reg <= hex_reg;
            ey_reg <= hey_reg;
        end
    end

    assign m_valid        = ov_reg;
    assign m_start_x      = sx_reg;
    assign m_start_y      = sy_reg;
    assign m_end_x        = ex_reg;
    assign m_end_y        = ey_reg;
    assign m_level_number = lvn_reg;
    assign m_last_segment = ol_reg;

endmodule

### sv/contour_segment_extractor.sv
// contour_segment_extractor: top level of the marching squares segment block
// depends on cse_pkg, cse_front, cse_back, cse_div
//
// usage: samples enter in raster order on the s_ channel (valid/ready), one
// beat per sample; frame_start puts a sample at column 0, row 0. each 2x2
// cell closed by a sample is tested against up to 16 contour levels and each
// pair of edge crossings leaves as one segment beat on the m_ channel, the
// last one for the sample flagged by m_last_segment.
// a cell first runs the step division, then for each level a level set-up
// step and one test per edge, plus a division and a put step for each
// crossed edge; the shared bit-serial divider does both. a sample forming
// no cell passes the front idle and read states and the back drops it.
// the front part holds one finished cell while the back part works, so the
// next sample is taken while segments drain.
// reset (aresetn, synchronous, active low) clears the counters and handshakes;
// the line store keeps no reset. when m_ready is low, the segment register
// holds and the level sweep waits for it. configuration is written through
// cfg_wr_en/cfg_index/cfg_data, by the user only while idle; not enforced.
module contour_segment_extractor
    import cse_pkg::*;
#(
    parameter int MAX_ROW_LENGTH = DEF_MAX_ROW_LENGTH,
    parameter int MAX_LEVELS     = DEF_MAX_LEVELS,
    parameter int FRACTION_BITS  = DEF_FRACTION_BITS,
    parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_BITS-1:0]           cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_value,
    input  logic                          s_frame_start,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [COORD_BITS-1:0]         m_start_x,
    output logic [COORD_BITS-1:0]         m_start_y,
    output logic [COORD_BITS-1:0]         m_end_x,
    output logic [COORD_BITS-1:0]         m_end_y,
    output logic [LEVEL_BITS-1:0]         m_level_number,
    output logic                          m_last_segment
);

    logic [10:0]        row_length_reg;
    logic signed [15:0] level_base_reg, level_top_reg;
    logic [4:0]         level_request_reg;
    logic               job_valid, job_ready;
    cell_job_t          job;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg    <= 11'd1024;
            level_base_reg    <= 16'sd0;
            level_top_reg     <= 16'sd32767;
            level_request_reg <= 5'd7;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ROW_LENGTH:    row_length_reg    <= cfg_data[10:0];
                REG_LEVEL_BASE:    level_base_reg    <= cfg_data;
                REG_LEVEL_TOP:     level_top_reg     <= cfg_data;
                REG_LEVEL_REQUEST: level_request_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    cse_front #(
        .MAX_ROW_LENGTH(MAX_ROW_LENGTH), .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_sample_value(s_sample_value), .s_frame_start(s_frame_start),
        .row_length(row_length_reg),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    cse_back #(
        .MAX_LEVELS(MAX_LEVELS), .FRACTION_BITS(FRACTION_BITS)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .level_base(level_base_reg), .level_top(level_top_reg),
        .level_request(level_request_reg),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_start_x(m_start_x), .m_start_y(m_start_y),
        .m_end_x(m_end_x), .m_end_y(m_end_y),
        .m_level_number(m_level_number), .m_last_segment(m_last_segment)
    );

endmodule
